// ===== rtl/rrq_pkg.sv =====
package rrq_pkg;

  // Fixed field widths
  localparam int THREAD_ID_W = 4;
  localparam int OPCODE_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int QCOUNT_W    = 5;

  typedef logic [THREAD_ID_W-1:0] thread_id_t;
  typedef logic [OPCODE_W-1:0]    opcode_t;
  typedef logic [STATUS_W-1:0]    status_t;
  typedef logic [QCOUNT_W-1:0]    qcount_t;

  // Operation codes
  localparam opcode_t OP_YIELD = 2'd0;
  localparam opcode_t OP_ADD   = 2'd1;
  localparam opcode_t OP_TERM  = 2'd2;

  // Status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

endpackage

// ===== rtl/rrq_if.sv =====
// Operation channel
interface rrq_in_if import rrq_pkg::*; ();
  logic       valid;
  logic       ready;
  opcode_t    opcode;
  thread_id_t thread_id;

  modport source (output valid, output opcode, output thread_id, input ready);
  modport sink   (input valid, input opcode, input thread_id, output ready);
endinterface

// Result channel
interface rrq_out_if import rrq_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       dispatched;
  thread_id_t running_thread;
  status_t    status;
  qcount_t    queue_count;

  modport source (output valid, output dispatched, output running_thread,
                  output status, output queue_count, input ready);
  modport sink   (input valid, input dispatched, input running_thread,
                  input status, input queue_count, output ready);
endinterface

// Idle thread id write channel
interface rrq_cfg_if import rrq_pkg::*; ();
  logic       valid;
  logic       ready;
  thread_id_t idle_thread_id;

  modport source (output valid, output idle_thread_id, input ready);
  modport sink   (input valid, input idle_thread_id, output ready);
endinterface

// ===== rtl/rrq_ram.sv =====
module rrq_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/round_robin_ready_queue_top.sv =====
// Channel  Dir  Handshake      Payload
// cfg_if   in   valid/ready    idle_thread_id
// in_if    in   valid/ready    opcode, thread_id
// out_if   out  valid/ready    dispatched, running_thread, status, queue_count
//
// One item at a time. Add, no-op, yield on an empty queue and terminate on an
// empty queue finish straight from idle; yield and terminate of the running
// thread on a non-empty queue go through a pop (one read of the queue RAM).
// Terminate of a queued id scans from the head up to its position, one RAM read
// per cycle, then shifts any later entries down to close the gap; an id that is
// not queued is scanned across the whole queue.
// Synchronous active-low reset; the queue RAM needs no clearing pass.
// A result waiting on out_if.ready does not block the next transfer in; a second
// finished result then holds the sequencer until the output register frees up.
module round_robin_ready_queue_top import rrq_pkg::*; #(
  parameter int MAX_THREADS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  rrq_cfg_if.sink   cfg_if,
  rrq_in_if.sink    in_if,
  rrq_out_if.source out_if
);

  localparam int AW = $clog2(MAX_THREADS);
  localparam int CW = $clog2(MAX_THREADS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_THREADS);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POP   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  // Queue position to RAM address, circular from head
  function automatic logic [AW-1:0] pos_of(logic [AW-1:0] base, logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(MAX_THREADS)) begin
      s = s - (CW+1)'(MAX_THREADS);
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]    state_r, state_nxt;
  opcode_t       op_r;
  thread_id_t    tid_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  thread_id_t    cur_r, cur_nxt;
  thread_id_t    idle_r;
  logic          pend_disp_r;
  status_t       pend_status_r;

  logic          out_valid_r;
  logic          out_disp_r;
  thread_id_t    out_run_r;
  status_t       out_status_r;
  qcount_t       out_cnt_r;

  logic          in_xfer, out_free;
  logic          fin, fin_disp;
  status_t       fin_status;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  thread_id_t    ram_wdata, ram_rdata;

  rrq_ram #(
    .WIDTH (THREAD_ID_W),
    .DEPTH (MAX_THREADS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_if.ready  = (state_r == S_IDLE);
  assign in_xfer      = in_if.valid && in_if.ready;
  assign out_free     = !out_valid_r || out_if.ready;
  assign cfg_if.ready = 1'b1;

  // Sequencer: read the front or scan, modify, write back
  always_comb begin
    state_nxt  = state_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    cur_nxt    = cur_r;
    idx_nxt    = idx_r;
    ram_we     = 1'b0;
    ram_waddr  = head_r;
    ram_wdata  = cur_r;
    ram_raddr  = head_r;
    fin        = 1'b0;
    fin_disp   = 1'b0;
    fin_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (in_if.opcode)
            OP_YIELD: begin
              if (count_r == '0) begin
                fin = 1'b1;
              end else begin
                state_nxt = S_POP;
              end
            end
            OP_ADD: begin
              fin = 1'b1;
              if (count_r == MAX_CNT) begin
                fin_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_of(head_r, count_r);
                ram_wdata = in_if.thread_id;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_TERM: begin
              if (in_if.thread_id == cur_r) begin
                if (count_r == '0) begin
                  cur_nxt  = idle_r;
                  fin      = 1'b1;
                  fin_disp = 1'b1;
                end else begin
                  state_nxt = S_POP;
                end
              end else if (count_r == '0) begin
                fin        = 1'b1;
                fin_status = ST_NOT_FOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      S_POP: begin
        // front entry arrives; yield requeues the running thread at the tail
        cur_nxt  = ram_rdata;
        head_nxt = pos_of(head_r, CW'(1));
        fin      = 1'b1;
        fin_disp = 1'b1;
        if (op_r == OP_YIELD) begin
          ram_we    = 1'b1;
          ram_waddr = pos_of(head_r, count_r);
          ram_wdata = cur_r;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      S_SCAN: begin
        // compare entry idx, fetch entry idx+1
        ram_raddr = pos_of(head_r, idx_r + CW'(1));
        if (ram_rdata == tid_r) begin
          if (idx_r + CW'(1) == count_r) begin
            count_nxt = count_r - CW'(1);
            fin       = 1'b1;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (idx_r + CW'(1) == count_r) begin
          fin        = 1'b1;
          fin_status = ST_NOT_FOUND;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_SHIFT: begin
        // entry idx+1 moves down to idx
        ram_we    = 1'b1;
        ram_waddr = pos_of(head_r, idx_r);
        ram_wdata = ram_rdata;
        ram_raddr = pos_of(head_r, idx_r + CW'(2));
        if (idx_r + CW'(2) == count_r) begin
          count_nxt = count_r - CW'(1);
          fin       = 1'b1;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_DONE;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      cur_r   <= '0;
      idle_r  <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      count_r <= count_nxt;
      cur_r   <= cur_nxt;
      if (cfg_if.valid && cfg_if.ready) begin
        idle_r <= cfg_if.idle_thread_id;
      end
    end
  end

  // Item and scan registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r  <= in_if.opcode;
      tid_r <= in_if.thread_id;
    end
    idx_r <= idx_nxt;
    if (fin) begin
      pend_disp_r   <= fin_disp;
      pend_status_r <= fin_status;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin && out_free) begin
      out_valid_r <= 1'b1;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin && out_free) begin
      out_disp_r   <= fin_disp;
      out_run_r    <= cur_nxt;
      out_status_r <= fin_status;
      out_cnt_r    <= QCOUNT_W'(count_nxt);
    end else if (state_r == S_DONE && out_free) begin
      out_disp_r   <= pend_disp_r;
      out_run_r    <= cur_r;
      out_status_r <= pend_status_r;
      out_cnt_r    <= QCOUNT_W'(count_r);
    end
  end

  assign out_if.valid          = out_valid_r;
  assign out_if.dispatched     = out_disp_r;
  assign out_if.running_thread = out_run_r;
  assign out_if.status         = out_status_r;
  assign out_if.queue_count    = out_cnt_r;

  // Checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("queue count above capacity");

  a_shift_depth: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> (count_r >= CW'(2) && idx_r + CW'(2) <= count_r))
    else $error("shift past queue tail");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> idx_r < count_r)
    else $error("scan index outside queue");

  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_if.opcode == OP_ADD && count_r != MAX_CNT)
      |=> count_r == $past(count_r) + CW'(1))
    else $error("add did not grow queue");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> out_valid_r)
    else $error("result held with output register empty");

endmodule
